// ===== rtl/pfa_pkg.sv =====
// Package: sizes, status codes and sequencer states for the paged frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;
    localparam int FRAME_COUNT   = 256;
    localparam int PROCESS_SLOTS = 16;
    localparam int MAX_PAGES     = 64;
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int SLOT_W  = $clog2(PROCESS_SLOTS);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int COUNT_W = $clog2(MAX_PAGES + 1);
    localparam int FREE_W  = $clog2(FRAME_COUNT + 1);
    localparam int MAP_W   = SLOT_W + PAGE_W;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_LOOK,
        S_DONE
    } t_state;

    localparam logic FUNC_RESIZE = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;
endpackage

// ===== rtl/pfa_bitmap.sv =====
// Frame-in-use bitmap with a walking scan pointer for the lowest free frame.
`timescale 1ns / 1ps
module pfa_bitmap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_scan_start,
    input  logic                  i_scan_step,
    input  logic                  i_set,
    input  logic                  i_clr,
    input  logic [pfa_pkg::FRAME_W-1:0] i_clr_frame,
    output logic                  o_cur_free,
    output logic [pfa_pkg::FRAME_W-1:0] o_cur_frame
);
    import pfa_pkg::*;

    logic [FRAME_COUNT-1:0] r_used;
    logic [FRAME_W-1:0]     r_ptr;

    assign o_cur_frame = r_ptr;
    assign o_cur_free  = ~r_used[r_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr  <= '0;
        end else begin
            if (i_set) r_used[r_ptr] <= 1'b1;
            if (i_clr) r_used[i_clr_frame] <= 1'b0;
            if (i_scan_start) r_ptr <= '0;
            else if (i_scan_step) r_ptr <= r_ptr + 1'b1;
        end
    end
endmodule

// ===== rtl/pfa_map_ram.sv =====
// Page-to-frame map memory, one write and one registered read port.
`timescale 1ns / 1ps
module pfa_map_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [pfa_pkg::MAP_W-1:0]   i_waddr,
    input  logic [pfa_pkg::FRAME_W-1:0] i_wdata,
    input  logic [pfa_pkg::MAP_W-1:0]   i_raddr,
    output logic [pfa_pkg::FRAME_W-1:0] o_rdata
);
    import pfa_pkg::*;

    logic [FRAME_W-1:0] r_mem [PROCESS_SLOTS*MAX_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/paged_frame_allocator.sv =====
// Top level: sequencer that serves resize and lookup beats one at a time.
//
// Input channel: i_valid / o_stall with func, process_slot, page_count,
// page_number. Output channel: o_valid / i_stall with status, frame_number.
// One beat is taken while the block is idle; o_stall stays high until the
// result has left the output register. Every item gives one result.
// Steps: a lookup hit passes S_CHECK, S_LOOK and S_DONE. A shrink
// runs S_FREE_RD and S_FREE_WR once per dropped page. A grow walks the
// bitmap scan over frames (at most FRAME_COUNT) and grants a page at each
// free frame. The scan pointer restarts at frame zero for each
// grow, and the single bitmap read port and single map write port set the
// pace. A failed, same-size or not-found item goes from S_CHECK to S_DONE.
// Reset clears the bitmap, page counts and free count; the map
// memory is not cleared, since only granted entries are read.
// When the receiver stalls, the result holds and no new beat is taken.
`timescale 1ns / 1ps
module paged_frame_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [3:0] i_process_slot,
    input  logic [6:0] i_page_count,
    input  logic [5:0] i_page_number,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_frame_number
);
    import pfa_pkg::*;

    t_state r_state, n_state;
    logic               r_func;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_count;
    logic [PAGE_W-1:0]  r_page;
    logic [COUNT_W-1:0] r_held [PROCESS_SLOTS];
    logic [COUNT_W-1:0] r_p;
    logic [FREE_W-1:0]  r_free;
    t_status            r_status;
    logic [7:0]         r_frame;

    logic scan_start, scan_step, set_bit, clr_bit, map_we;
    logic cur_free;
    logic [FRAME_W-1:0] cur_frame, map_rd;
    logic [MAP_W-1:0]   raddr;
    logic [COUNT_W-1:0] held;

    assign held = r_held[r_slot];
    assign o_stall = (r_state != S_IDLE);
    assign raddr = (r_state == S_LOOK || r_state == S_CHECK) ?
                   {r_slot, r_page} : {r_slot, r_p[PAGE_W-1:0]};

    pfa_bitmap u_bitmap (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_scan_start(scan_start), .i_scan_step(scan_step),
        .i_set(set_bit), .i_clr(clr_bit), .i_clr_frame(map_rd),
        .o_cur_free(cur_free), .o_cur_frame(cur_frame)
    );

    pfa_map_ram u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr({r_slot, r_p[PAGE_W-1:0]}),
        .i_wdata(cur_frame), .i_raddr(raddr), .o_rdata(map_rd)
    );

    always_comb begin
        n_state = r_state;
        scan_start = 1'b0;
        scan_step  = 1'b0;
        set_bit    = 1'b0;
        clr_bit    = 1'b0;
        map_we     = 1'b0;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = S_CHECK;
            S_CHECK: begin
                scan_start = 1'b1;
                if (r_func == FUNC_LOOKUP) begin
                    n_state = ({1'b0, r_page} < held) ? S_LOOK : S_DONE;
                end else if (r_count > COUNT_W'(MAX_PAGES) || r_count == held) begin
                    n_state = S_DONE;
                end else if (r_count > held) begin
                    n_state = (FREE_W'(r_count - held) > r_free) ? S_DONE : S_SCAN;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_SCAN: begin
                if (r_p == r_count) n_state = S_DONE;
                else if (cur_free) begin
                    set_bit = 1'b1;
                    map_we  = 1'b1;
                end else scan_step = 1'b1;
            end
            S_FREE_RD: n_state = (r_p == held) ? S_DONE : S_FREE_WR;
            S_FREE_WR: begin
                clr_bit = 1'b1;
                n_state = S_FREE_RD;
            end
            S_LOOK:    n_state = S_DONE;
            S_DONE:    if (!i_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= FREE_W'(FRAME_COUNT);
            for (int i = 0; i < PROCESS_SLOTS; i++) r_held[i] <= '0;
        end else begin
            r_state <= n_state;
            if (set_bit) r_free <= r_free - 1'b1;
            if (clr_bit) r_free <= r_free + 1'b1;
            if (r_state == S_CHECK) begin
                r_frame  <= '0;
                r_status <= ST_OK;
                if (r_func == FUNC_LOOKUP) begin
                    if (!({1'b0, r_page} < held)) r_status <= ST_NOT_FOUND;
                end else if (r_count > COUNT_W'(MAX_PAGES)) begin
                    r_status <= ST_OOM;
                end else if (r_count > held) begin
                    if (FREE_W'(r_count - held) > r_free) r_status <= ST_OOM;
                    else r_held[r_slot] <= r_count;
                    r_p <= held;
                end else begin
                    r_p <= r_count;
                end
            end
            if (set_bit) r_p <= r_p + 1'b1;
            if (r_state == S_FREE_RD && r_p != held) r_p <= r_p + 1'b1;
            if (r_state == S_FREE_RD && r_p == held) r_held[r_slot] <= r_count;
            if (r_state == S_LOOK) r_frame <= 8'(map_rd);
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_func  <= i_func;
            r_slot  <= i_process_slot;
            r_count <= i_page_count;
            r_page  <= i_page_number;
        end
    end

    assign o_valid        = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_frame_number = r_frame;
endmodule

// ===== rtl/pfa_checker.sv =====
// Port-level checker for the paged frame allocator, bound to the top level.
`timescale 1ns / 1ps
module pfa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [7:0] o_frame_number
);
    import pfa_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("no stall after accept");
    a_no_out_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid) else $error("result while idle");
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_OOM || o_status == ST_NOT_FOUND))
        else $error("bad status");
    a_frame_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_frame_number == 8'd0)
        else $error("frame on failure");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)))
        else $error("stalled result changed");
endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_frame_number(o_frame_number)
);

// ===== dv/tb_paged_frame_allocator.sv =====
// Testbench: directed table and random resize/lookup beats checked against a frame allocator model.
`timescale 1ns / 1ps
module tb_paged_frame_allocator;
    import pfa_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_func = FUNC_RESIZE;
    logic [3:0] i_process_slot = '0;
    logic [6:0] i_page_count = '0;
    logic [5:0] i_page_number = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_frame_number;

    paged_frame_allocator u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame;
    } t_answer;

    // allocator mirror
    logic                 frame_busy [FRAME_COUNT];
    logic [COUNT_W-1:0]   held_pages [PROCESS_SLOTS];
    logic [FRAME_W-1:0]   page_map   [PROCESS_SLOTS*MAX_PAGES];
    int                   frames_left;

    t_answer answer_q [$];
    int      fail_count = 0;
    int      hold_off = 0;
    bit      long_hold = 1'b0;
    bit      long_done = 1'b0;

    function automatic t_answer serve(logic func, logic [3:0] slot, logic [6:0] cnt,
                                      logic [5:0] page);
        t_answer a;
        int held;
        int f;
        a = '{status: ST_OK, frame: '0};
        if (func == FUNC_LOOKUP) begin
            if (slot < PROCESS_SLOTS && page < held_pages[slot])
                a.frame = page_map[slot*MAX_PAGES + page];
            else
                a.status = ST_NOT_FOUND;
            return a;
        end
        if (slot >= PROCESS_SLOTS || cnt > MAX_PAGES) begin
            a.status = ST_OOM;
            return a;
        end
        held = held_pages[slot];
        if (cnt > held) begin
            if (cnt - held > frames_left) begin
                a.status = ST_OOM;
                return a;
            end
            for (int p = held; p < cnt; p++) begin
                f = 0;
                while (frame_busy[f]) f++;
                frame_busy[f] = 1'b1;
                frames_left--;
                page_map[slot*MAX_PAGES + p] = f[FRAME_W-1:0];
            end
        end else begin
            for (int p = cnt; p < held; p++) begin
                f = page_map[slot*MAX_PAGES + p];
                if (frame_busy[f]) begin
                    frame_busy[f] = 1'b0;
                    frames_left++;
                end
            end
        end
        held_pages[slot] = cnt;
        return a;
    endfunction

    // directed rows; fixed answers where obvious, else chk=0 uses the mirror
    typedef struct {
        logic       func;
        logic [3:0] slot;
        logic [6:0] cnt;
        logic [5:0] page;
        bit         chk;
        t_answer    ans;
    } t_row;

    t_row rows [] = '{
        '{FUNC_LOOKUP, 4'd0,  7'd0,   6'd0,  1, '{ST_NOT_FOUND, 8'd0}},
        '{FUNC_LOOKUP, 4'd15, 7'd127, 6'd63, 1, '{ST_NOT_FOUND, 8'd0}},
        '{FUNC_RESIZE, 4'd0,  7'd0,   6'd0,  1, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd3,  7'd65,  6'd0,  1, '{ST_OOM, 8'd0}},
        '{FUNC_RESIZE, 4'd3,  7'd127, 6'd63, 1, '{ST_OOM, 8'd0}},
        '{FUNC_RESIZE, 4'd0,  7'd64,  6'd0,  1, '{ST_OK, 8'd0}},
        '{FUNC_LOOKUP, 4'd0,  7'd0,   6'd0,  1, '{ST_OK, 8'd0}},
        '{FUNC_LOOKUP, 4'd0,  7'd0,   6'd63, 1, '{ST_OK, 8'd63}},
        '{FUNC_LOOKUP, 4'd0,  7'd0,   6'd63, 0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd1,  7'd64,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd2,  7'd64,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd15, 7'd64,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_LOOKUP, 4'd15, 7'd0,   6'd63, 1, '{ST_OK, 8'd255}},
        '{FUNC_RESIZE, 4'd4,  7'd1,   6'd0,  1, '{ST_OOM, 8'd0}},
        '{FUNC_RESIZE, 4'd1,  7'd64,  6'd0,  1, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd1,  7'd10,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_LOOKUP, 4'd1,  7'd0,   6'd10, 1, '{ST_NOT_FOUND, 8'd0}},
        '{FUNC_LOOKUP, 4'd1,  7'd0,   6'd9,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd4,  7'd20,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_LOOKUP, 4'd4,  7'd42,  6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd0,  7'd0,   6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd2,  7'd0,   6'd0,  0, '{ST_OK, 8'd0}},
        '{FUNC_RESIZE, 4'd15, 7'd0,   6'd0,  0, '{ST_OK, 8'd0}}
    };

    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_beat(logic func, logic [3:0] slot, logic [6:0] cnt,
                             logic [5:0] page, bit chk, t_answer ans);
        t_answer pred;
        i_valid        <= 1'b1;
        i_func         <= func;
        i_process_slot <= slot;
        i_page_count   <= cnt;
        i_page_number  <= page;
        do @(posedge i_clk); while (o_stall);
        pred = serve(func, slot, cnt, page);
        if (chk && pred != ans) begin
            $error("table row disagrees with mirror: status exp %0d act %0d, frame exp %0d act %0d",
                   ans.status, pred.status, ans.frame, pred.frame);
            fail_count++;
        end
        answer_q.push_back(chk ? ans : pred);
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else if (long_hold && !long_done) begin
            long_done <= 1'b1;
            hold_off  <= 600;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 40) == 0) hold_off <= $urandom_range(5, 30);
        end
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answer_q.size() == 0) begin
                $error("result with none expected: status %0d frame %0d",
                       o_status, o_frame_number);
                fail_count++;
            end else begin
                e = answer_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d act %0d", e.status, o_status);
                    fail_count++;
                end
                if (o_frame_number !== e.frame) begin
                    $error("frame_number exp %0d act %0d", e.frame, o_frame_number);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("paged_frame_allocator regression: fail");
        $finish;
    end

    initial begin
        logic       f;
        logic [3:0] s;
        logic [6:0] c;
        logic [5:0] p;
        int         r;
        for (int k = 0; k < FRAME_COUNT; k++) frame_busy[k] = 1'b0;
        for (int k = 0; k < PROCESS_SLOTS; k++) held_pages[k] = '0;
        frames_left = FRAME_COUNT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) begin
            send_beat(rows[k].func, rows[k].slot, rows[k].cnt, rows[k].page,
                      rows[k].chk, rows[k].ans);
            idle_gap();
        end
        for (int n = 0; n < 1150; n++) begin
            if (n == 300) long_hold = 1'b1;
            if (n == 700) begin
                // drain before continuing
                i_valid <= 1'b0;
                while (answer_q.size() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            s = 4'($urandom);
            p = 6'($urandom);
            if (r < 40) begin
                f = FUNC_LOOKUP;
                c = 7'($urandom);
                if (held_pages[s] != 0 && $urandom_range(0, 3) != 0)
                    p = 6'($urandom_range(0, held_pages[s] - 1));
            end else begin
                f = FUNC_RESIZE;
                if (r < 45) c = 7'($urandom_range(65, 127));
                else if (r < 55) c = 7'($urandom_range(0, 64));
                else if (r < 60) c = held_pages[s];
                else c = 7'($urandom_range(0, 12));
            end
            send_beat(f, s, c, p, 0, '{ST_OK, 8'd0});
            idle_gap();
        end
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && answer_q.size() == 0)
            $display("paged_frame_allocator regression: pass");
        else
            $display("paged_frame_allocator regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/pfa_pkg.sv
rtl/pfa_bitmap.sv
rtl/pfa_map_ram.sv
rtl/paged_frame_allocator.sv
rtl/pfa_checker.sv
dv/tb_paged_frame_allocator.sv
